// File: rtl/core/mcf_pkg.sv
// Shared constants, types and a helper function of the message chunk fragmenter.
package mcf_pkg;

   localparam int CHUNK_BYTES        = 4096;
   localparam int SEGMENTS           = 8;
   localparam int CHUNKS_PER_SEGMENT = 4;
   localparam int DEFAULT_LIMIT      = 16384;
   localparam int PER_CALL_LIMIT     = 16384;

   localparam int ADDR_W  = 32;
   localparam int LIM_W   = 16;
   localparam int IDX_W   = 16;
   localparam int CHUNK_W = 13;
   localparam int SEG_W   = $clog2(SEGMENTS + 1);
   localparam int J_W     = (CHUNKS_PER_SEGMENT > 1) ? $clog2(CHUNKS_PER_SEGMENT) : 1;

   localparam logic [LIM_W:0]   CHUNK_MAX  = (LIM_W + 1)'(CHUNK_BYTES);
   localparam logic [ADDR_W-1:0] CHUNK_STEP = ADDR_W'(CHUNK_BYTES);
   localparam logic [SEG_W-1:0] SEG_MAX    = SEG_W'(SEGMENTS);
   localparam logic [J_W-1:0]   J_LAST     = J_W'(CHUNKS_PER_SEGMENT - 1);

   typedef struct packed {
      logic accept;
      logic load;
      logic clamp;
      logic fire;
   } cmd_type;

   typedef struct packed {
      logic go;
      logic last;
   } sts_type;

   function automatic logic [LIM_W-1:0] limit_of(input logic [LIM_W-1:0] setting);
      logic [LIM_W-1:0] lim;
      lim = setting;
      if (setting == '0) begin
         lim = LIM_W'(DEFAULT_LIMIT);
      end else begin
         if (lim > LIM_W'(DEFAULT_LIMIT)) lim = LIM_W'(DEFAULT_LIMIT);
         if (lim > LIM_W'(PER_CALL_LIMIT)) lim = LIM_W'(PER_CALL_LIMIT);
      end
      return lim;
   endfunction

endpackage

// File: rtl/core/mcf_ctrl.sv
// Controller state machine that sequences segment intake and fragment output.
module mcf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  mcf_pkg::sts_type sts,
   output mcf_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOAD  = 2'd1;
   localparam logic [1:0] ST_CLAMP = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign fire       = (state_ff == ST_EMIT) && (!valid_ff || rsp_tready);

   assign cmd.accept = req_tvalid && req_tready;
   assign cmd.load   = (state_ff == ST_LOAD);
   assign cmd.clamp  = (state_ff == ST_CLAMP);
   assign cmd.fire   = fire;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            state_in = sts.go ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (fire && sts.last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (fire) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// File: rtl/core/mcf_dp.sv
// Datapath holding the message state, the length clamping and the fragment registers.
module mcf_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  mcf_pkg::cmd_type                    cmd,
   output mcf_pkg::sts_type                    sts,
   input  logic                                csr_wr_en,
   input  logic [mcf_pkg::LIM_W-1:0]           csr_wr_data,
   input  logic                                in_first,
   input  logic [mcf_pkg::ADDR_W-1:0]          in_message_len,
   input  logic [mcf_pkg::ADDR_W-1:0]          in_segment_len,
   input  logic [mcf_pkg::ADDR_W-1:0]          in_segment_skip,
   input  logic                                in_direction,
   output logic [mcf_pkg::IDX_W-1:0]           out_frag_index,
   output logic [mcf_pkg::CHUNK_W-1:0]         out_chunk_len,
   output logic [mcf_pkg::ADDR_W-1:0]          out_chunk_offset,
   output logic [mcf_pkg::LIM_W-1:0]           out_total_len_low,
   output logic                                out_start_mark,
   output logic                                out_end_mark,
   output logic                                out_truncated_mark,
   output logic                                out_direction,
   output logic                                out_last_of_run
);

   localparam int AW = mcf_pkg::ADDR_W;
   localparam int LW = mcf_pkg::LIM_W;
   localparam int SW = mcf_pkg::SEG_W;
   localparam int IW = mcf_pkg::IDX_W;
   localparam int JW = mcf_pkg::J_W;

   logic [LW-1:0]             csr_ff;
   logic                      first_ff;
   logic [AW-1:0]             msg_in_ff, seg_len_ff, skip_in_ff;
   logic                      dir_in_ff;

   logic [AW-1:0]             held_len_ff;
   logic                      held_dir_ff, trunc_ff;
   logic [LW-1:0]             cap_ff;
   logic [mcf_pkg::IDX_W-1:0] fc_ff;
   logic [mcf_pkg::SEG_W-1:0] sc_ff;

   logic [AW-1:0]             avail_ff, room_msg_ff, off_ff;
   logic [LW-1:0]             room_lim_ff, limit_ff, len_ff;
   logic                      go_ff;
   logic [mcf_pkg::J_W-1:0]   j_ff;

   logic [mcf_pkg::IDX_W-1:0]   frag_index_ff;
   logic [mcf_pkg::CHUNK_W-1:0] chunk_len_ff;
   logic [AW-1:0]               chunk_offset_ff;
   logic [LW-1:0]               total_ff;
   logic                        start_ff, end_ff, trunc_out_ff, dir_out_ff, last_ff;

   logic [LW-1:0]             limit;
   logic [LW-1:0]             cap_eff;
   logic [AW-1:0]             mlen_eff, skip_eff;
   logic [mcf_pkg::SEG_W-1:0] sc_eff;
   logic                      seg_ok, done, skip_ge;

   logic [AW-1:0]             min_one;
   logic [LW-1:0]             len_in;

   logic [LW-1:0]             chunk;
   logic [LW:0]               sum;
   logic [LW-1:0]             rest;
   logic                      end_hit, last;

   assign limit    = mcf_pkg::limit_of(csr_ff);
   assign cap_eff  = first_ff ? '0 : cap_ff;
   assign mlen_eff = first_ff ? msg_in_ff : held_len_ff;
   assign skip_eff = first_ff ? skip_in_ff : '0;
   assign sc_eff   = first_ff ? '0 : sc_ff;
   assign seg_ok   = sc_eff < mcf_pkg::SEG_MAX;
   assign done     = ({{(AW-LW){1'b0}}, cap_eff} >= mlen_eff) || (cap_eff >= limit);
   assign skip_ge  = skip_eff >= seg_len_ff;

   assign min_one = (avail_ff < room_msg_ff) ? avail_ff : room_msg_ff;
   assign len_in  = (min_one < {{(AW-LW){1'b0}}, room_lim_ff}) ? min_one[LW-1:0] : room_lim_ff;

   assign chunk   = ({1'b0, len_ff} > mcf_pkg::CHUNK_MAX) ? mcf_pkg::CHUNK_MAX[LW-1:0] : len_ff;
   assign sum     = {1'b0, cap_ff} + {1'b0, chunk};
   assign rest    = len_ff - chunk;
   assign end_hit = ({{(AW-LW-1){1'b0}}, sum} >= held_len_ff) || (sum >= {1'b0, limit_ff});
   assign last    = (rest == '0) || (j_ff == mcf_pkg::J_LAST);

   assign sts.go   = go_ff;
   assign sts.last = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff      <= '0;
         held_len_ff <= '0;
         held_dir_ff <= 1'b0;
         trunc_ff    <= 1'b0;
         cap_ff      <= '0;
         fc_ff       <= '0;
         sc_ff       <= '0;
      end else begin
         if (csr_wr_en) csr_ff <= csr_wr_data;
         if (cmd.load) begin
            if (first_ff) begin
               held_len_ff <= msg_in_ff;
               held_dir_ff <= dir_in_ff;
               trunc_ff    <= msg_in_ff > {{(AW-LW){1'b0}}, limit};
               fc_ff       <= '0;
            end
            cap_ff <= cap_eff;
            sc_ff  <= seg_ok ? sc_eff + SW'(1) : sc_eff;
         end else if (cmd.fire) begin
            cap_ff <= sum[LW-1:0];
            fc_ff  <= fc_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         first_ff   <= in_first;
         msg_in_ff  <= in_message_len;
         seg_len_ff <= in_segment_len;
         skip_in_ff <= in_segment_skip;
         dir_in_ff  <= in_direction;
      end
      if (cmd.load) begin
         avail_ff    <= seg_len_ff - skip_eff;
         room_msg_ff <= mlen_eff - {{(AW-LW){1'b0}}, cap_eff};
         room_lim_ff <= limit - cap_eff;
         limit_ff    <= limit;
         off_ff      <= skip_eff;
         go_ff       <= seg_ok && !done && !skip_ge;
      end
      if (cmd.clamp) begin
         len_ff <= len_in;
         j_ff   <= '0;
      end
      if (cmd.fire) begin
         frag_index_ff   <= fc_ff;
         chunk_len_ff    <= chunk[mcf_pkg::CHUNK_W-1:0];
         chunk_offset_ff <= off_ff;
         total_ff        <= held_len_ff[LW-1:0];
         start_ff        <= (fc_ff == '0);
         end_ff          <= end_hit;
         trunc_out_ff    <= trunc_ff;
         dir_out_ff      <= held_dir_ff;
         last_ff         <= last;
         len_ff          <= rest;
         off_ff          <= off_ff + mcf_pkg::CHUNK_STEP;
         j_ff            <= j_ff + JW'(1);
      end
   end

   assign out_frag_index     = frag_index_ff;
   assign out_chunk_len      = chunk_len_ff;
   assign out_chunk_offset   = chunk_offset_ff;
   assign out_total_len_low  = total_ff;
   assign out_start_mark     = start_ff;
   assign out_end_mark       = end_ff;
   assign out_truncated_mark = trunc_out_ff;
   assign out_direction      = dir_out_ff;
   assign out_last_of_run    = last_ff;

endmodule

// File: rtl/core/message_chunk_fragmenter.sv
// Top level of the message chunk fragmenter, joining controller and datapath.
// An accepted segment item passes the load and clamp set-up states and then gives one fragment
// item per cycle while the output register is free or being taken. The block takes no new segment
// item until its last fragment is issued; the first fragment is registered from the emit state.
// The fragment rate is set by the single output register, which is refilled as it is taken.
// Synchronous active-high reset clears the message state, the capture limit and the handshakes.
module message_chunk_fragmenter (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,  // message_len, segment_len, segment_skip
   input  logic [1:0]   req_tuser,  // first_segment, direction
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata,  // frag_index, chunk_len, chunk_offset, total_len_low, zeros
   output logic [3:0]   rsp_tuser,  // start_mark, end_mark, truncated_mark, out_direction
   output logic         rsp_tlast   // last_of_run
);

   mcf_pkg::cmd_type cmd;
   mcf_pkg::sts_type sts;

   logic [15:0] frag_index;
   logic [12:0] chunk_len;
   logic [31:0] chunk_offset;
   logic [15:0] total_len_low;

   mcf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mcf_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .in_first           (req_tuser[0]),
      .in_message_len     (req_tdata[31:0]),
      .in_segment_len     (req_tdata[63:32]),
      .in_segment_skip    (req_tdata[95:64]),
      .in_direction       (req_tuser[1]),
      .out_frag_index     (frag_index),
      .out_chunk_len      (chunk_len),
      .out_chunk_offset   (chunk_offset),
      .out_total_len_low  (total_len_low),
      .out_start_mark     (rsp_tuser[0]),
      .out_end_mark       (rsp_tuser[1]),
      .out_truncated_mark (rsp_tuser[2]),
      .out_direction      (rsp_tuser[3]),
      .out_last_of_run    (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, total_len_low, chunk_offset, chunk_len, frag_index};

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("block took a new item straight after accepting one");

   a_start_is_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("start fragment carries a non-zero index");

   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tlast)
      else $error("end fragment is not the last of its run");

endmodule

// File: tb/message_chunk_fragmenter_tb.sv
// Self-checking testbench of the message chunk fragmenter, with a fragment predictor.
`timescale 1ns / 100ps

module message_chunk_fragmenter_tb;

   typedef struct {
      logic [15:0] frag_index;
      logic [12:0] chunk_len;
      logic [31:0] chunk_offset;
      logic [15:0] total_len_low;
      logic        start_mark;
      logic        end_mark;
      logic        truncated_mark;
      logic        direction;
      logic        last_of_run;
   } frag_type;

   class frag_scoreboard_type;
      bit [15:0] limit_setting;
      bit [31:0] captured_bytes;
      bit [15:0] frag_count;
      int        seg_count;
      bit [31:0] msg_len;
      bit        msg_dir;
      bit        msg_trunc;
      frag_type  pending[$];
      int        errors;

      function void set_limit(bit [15:0] value);
         limit_setting = value;
      endfunction

      function int unsigned active_limit();
         int unsigned lim;
         lim = limit_setting;
         if (lim == 0) begin
            lim = mcf_pkg::DEFAULT_LIMIT;
         end else begin
            if (lim > mcf_pkg::DEFAULT_LIMIT) lim = mcf_pkg::DEFAULT_LIMIT;
            if (lim > mcf_pkg::PER_CALL_LIMIT) lim = mcf_pkg::PER_CALL_LIMIT;
         end
         return lim;
      endfunction

      function void note_segment(bit first, bit [31:0] mlen, bit [31:0] slen,
                                 bit [31:0] skip, bit dir);
         logic [63:0] lim;
         logic [63:0] skip_used;
         logic [63:0] remain;
         logic [63:0] chunk;
         logic [63:0] offset;
         frag_type    frag;
         frag_type    prev;
         bit          have_prev;
         int          j;
         lim = active_limit();
         skip_used = 0;
         have_prev = 1'b0;
         if (first) begin
            captured_bytes = 0;
            frag_count = 0;
            seg_count = 0;
            msg_len = mlen;
            msg_dir = dir;
            msg_trunc = (64'(mlen) > lim);
            skip_used = skip;
         end
         if (seg_count >= mcf_pkg::SEGMENTS) return;
         seg_count++;
         if (captured_bytes >= msg_len || captured_bytes >= lim) return;
         if (skip_used >= 64'(slen)) return;
         remain = 64'(slen) - skip_used;
         if (remain > 64'(msg_len - captured_bytes)) remain = 64'(msg_len - captured_bytes);
         if (remain > lim - 64'(captured_bytes)) remain = lim - 64'(captured_bytes);
         for (j = 0; j < mcf_pkg::CHUNKS_PER_SEGMENT; j++) begin
            if (remain == 0 || captured_bytes >= msg_len || captured_bytes >= lim) break;
            chunk = (remain > mcf_pkg::CHUNK_BYTES) ? 64'(mcf_pkg::CHUNK_BYTES) : remain;
            offset = skip_used + 64'(j) * 64'(mcf_pkg::CHUNK_BYTES);
            frag.frag_index = frag_count;
            frag.chunk_len = chunk[12:0];
            frag.chunk_offset = offset[31:0];
            frag.total_len_low = msg_len[15:0];
            frag.start_mark = (frag_count == 0);
            frag.end_mark = (64'(captured_bytes) + chunk >= 64'(msg_len)) ||
                            (64'(captured_bytes) + chunk >= lim);
            frag.truncated_mark = msg_trunc;
            frag.direction = msg_dir;
            frag.last_of_run = 1'b0;
            if (have_prev) pending.push_back(prev);
            prev = frag;
            have_prev = 1'b1;
            remain = remain - chunk;
            captured_bytes = captured_bytes + chunk[31:0];
            frag_count = frag_count + 16'd1;
         end
         if (have_prev) begin
            prev.last_of_run = 1'b1;
            pending.push_back(prev);
         end
      endfunction

      task report(string what, logic [63:0] want, logic [63:0] got);
         $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
         errors++;
      endtask

      task check_frag(frag_type got);
         frag_type want;
         if (pending.size() == 0) begin
            report("unexpected fragment, index", 0, got.frag_index);
            return;
         end
         want = pending.pop_front();
         if (got.frag_index !== want.frag_index)
            report("frag_index", want.frag_index, got.frag_index);
         if (got.chunk_len !== want.chunk_len)
            report("chunk_len", want.chunk_len, got.chunk_len);
         if (got.chunk_offset !== want.chunk_offset)
            report("chunk_offset", want.chunk_offset, got.chunk_offset);
         if (got.total_len_low !== want.total_len_low)
            report("total_len_low", want.total_len_low, got.total_len_low);
         if (got.start_mark !== want.start_mark)
            report("start_mark", want.start_mark, got.start_mark);
         if (got.end_mark !== want.end_mark)
            report("end_mark", want.end_mark, got.end_mark);
         if (got.truncated_mark !== want.truncated_mark)
            report("truncated_mark", want.truncated_mark, got.truncated_mark);
         if (got.direction !== want.direction)
            report("out_direction", want.direction, got.direction);
         if (got.last_of_run !== want.last_of_run)
            report("last_of_run", want.last_of_run, got.last_of_run);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;

   frag_scoreboard_type sb = new();
   frag_type            rx_frag;
   int                  burst_left = 0;
   int                  segs_left = 0;
   int                  stall_left = 0;
   int                  stall_mode = 0;
   logic [7:0]          stall_mask = 8'hff;
   int                  quiet_cycles = 0;
   int                  phase;

   message_chunk_fragmenter i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rx_frag.frag_index = rsp_tdata[15:0];
         rx_frag.chunk_len = rsp_tdata[28:16];
         rx_frag.chunk_offset = rsp_tdata[60:29];
         rx_frag.total_len_low = rsp_tdata[76:61];
         rx_frag.start_mark = rsp_tuser[0];
         rx_frag.end_mark = rsp_tuser[1];
         rx_frag.truncated_mark = rsp_tuser[2];
         rx_frag.direction = rsp_tuser[3];
         rx_frag.last_of_run = rsp_tlast;
         sb.check_frag(rx_frag);
      end
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(40, 200);
         stall_mask = 8'($urandom_range(1, 255));
      end
      stall_left--;
      stall_mask = {stall_mask[6:0], stall_mask[7]};
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= stall_mask[0];
         default: rsp_tready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= 3000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic feed_segment(input bit first, input bit [31:0] mlen, input bit [31:0] slen,
                               input bit [31:0] skip, input bit dir);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {skip, slen, mlen};
      req_tuser <= {dir, first};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_segment(first, mlen, slen, skip, dir);
      burst_left--;
   endtask

   // A segment can give no fragment at all, so the block is given its full
   // occupancy time again once the last expected fragment has arrived.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic program_limit(input bit [15:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      sb.set_limit(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random_segment();
      bit [31:0] mlen;
      bit [31:0] slen;
      bit [31:0] skip;
      bit        first;
      bit        dir;
      mlen = $urandom();
      skip = $urandom();
      dir = $urandom_range(0, 1);
      first = (segs_left == 0);
      case ($urandom_range(0, 19))
         0, 1:       slen = $urandom_range(0, 64);
         2, 3, 4, 5, 6, 7, 8, 9, 10, 11: slen = $urandom_range(1, 6000);
         12, 13, 14, 15, 16: slen = $urandom_range(1, 20000);
         default:    slen = $urandom();
      endcase
      if (first) begin
         segs_left = ($urandom_range(0, 6) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 5);
         case ($urandom_range(0, 9))
            0, 1:    mlen = $urandom_range(1, 3000);
            2, 3, 4: mlen = $urandom_range(1, 20000);
            5:       mlen = 32'(16382 + $urandom_range(0, 4));
            6:       mlen = $urandom_range(0, 100);
            default: mlen = $urandom();
         endcase
         case ($urandom_range(0, 9))
            6, 7:    skip = $urandom_range(0, 500);
            8:       skip = slen;
            9:       skip = $urandom();
            default: skip = 32'd0;
         endcase
      end
      segs_left--;
      feed_segment(first, mlen, slen, skip, dir);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      program_limit(16'd0);

      feed_segment(1'b0, 32'd500, 32'd100, 32'd0, 1'b0);
      feed_segment(1'b1, 32'd0, 32'd100, 32'd0, 1'b1);
      feed_segment(1'b1, 32'd10000, 32'd20000, 32'd0, 1'b1);
      feed_segment(1'b0, 32'd0, 32'd50, 32'd0, 1'b0);
      feed_segment(1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'd5, 1'b0);
      feed_segment(1'b1, 32'd5000, 32'd10, 32'd10, 1'b1);
      feed_segment(1'b0, 32'hffff_ffff, 32'd1, 32'hffff_ffff, 1'b1);
      feed_segment(1'b1, 32'd16384, 32'd16384, 32'd0, 1'b0);
      feed_segment(1'b1, 32'd16385, 32'd4096, 32'd0, 1'b1);
      feed_segment(1'b1, 32'd1000, 32'd0, 32'd0, 1'b0);
      repeat (9) feed_segment(1'b0, $urandom(), 32'd1, $urandom(), 1'b1);
      feed_segment(1'b1, 32'd20000, 32'd5000, 32'hffff_ffff, 1'b1);
      feed_segment(1'b1, 32'd20000, 32'd5000, 32'd100, 1'b0);
      program_limit(16'd3000);
      feed_segment(1'b0, 32'd0, 32'd1000, 32'd0, 1'b0);
      program_limit(16'd1);
      feed_segment(1'b1, 32'd50, 32'd50, 32'd0, 1'b1);
      feed_segment(1'b0, 32'd0, 32'd10, 32'd0, 1'b0);
      program_limit(16'hffff);
      feed_segment(1'b1, 32'd17000, 32'd17000, 32'd0, 1'b0);

      for (phase = 0; phase < 9; phase++) begin
         case (phase)
            0:       program_limit(16'd16384);
            1:       program_limit(16'hffff);
            2:       program_limit(16'd1);
            3:       program_limit(16'd16385);
            4:       program_limit(16'd4096);
            5:       program_limit(16'($urandom_range(1, 16383)));
            6:       program_limit(16'd0);
            7:       program_limit(16'($urandom_range(16385, 65535)));
            default: program_limit(16'($urandom_range(2, 600)));
         endcase
         repeat (50) send_random_segment();
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
